// File: design/ipv4dp_pkg.sv
// shared types and constants for the ipv4 dotted address parser
// no dependencies

package ipv4dp_pkg;

	// most parts a dotted address may hold
	localparam int unsigned MAX_PARTS = 4;
	localparam int unsigned SAVED_W = $clog2(MAX_PARTS - 1);

	// characters that steer the parser
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_LX    = 8'h78;
	localparam logic [7:0] CHR_UX    = 8'h58;
	localparam logic [7:0] CHR_LA    = 8'h61;
	localparam logic [7:0] CHR_LF    = 8'h66;
	localparam logic [7:0] CHR_UA    = 8'h41;
	localparam logic [7:0] CHR_UF    = 8'h46;
	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_CR    = 8'h0D;

	// radix of the part being read
	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	// one input word: a character and the end-of-string mark
	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} item_t;

	// one result word
	typedef struct packed {
		logic [31:0] address;
		logic        ok;
	} result_t;

endpackage

// File: design/ipv4_dotted_address_parser.sv
// ipv4 dotted address parser, top level
// depends on ipv4dp_pkg
//
// Usage:
// The item channel (item_valid/item_ready/item) takes one character of an
// address string per word; final_byte marks the last character. Parts may be
// decimal, octal (leading 0) or hex (leading 0x), in a, a.b, a.b.c or a.b.c.d
// form. A NUL or whitespace ends parsing; later characters up to the final
// one are ignored. Exactly one word leaves on the result channel
// (result_valid/result_ready/result) per string: the address with the first
// part in the top byte and ok set, or address 0 and ok clear on error.
// Throughput: one character per clock, strings back to back with no gap,
// unless a final character waits for the result register to free.
// Each character crosses an input register and one pass of parse logic, and a
// final one the result register; the parse state updates once per character.
// Reset clears both stages and the parse state, so no result is pending.
// When the receiver stalls, the result register holds its word; characters
// that produce no result keep flowing, and a final character waits in the
// input register until the result register frees, which then holds item_ready.

module ipv4_dotted_address_parser
	import ipv4dp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// input register
	logic  valid_s1;
	item_t item_s1;

	// result register
	logic    valid_s2;
	result_t result_s2;

	// parse state
	logic [31:0]        acc_q;
	base_t              base_q;
	logic               part_start_q;
	logic               lead_zero_q;
	logic [7:0]         saved_q [MAX_PARTS-1];
	logic [SAVED_W-1:0] parts_seen_q;
	logic               stopped_q;
	logic               failed_q;

	// next parse state
	logic [31:0]        acc_d;
	base_t              base_d;
	logic               part_start_d;
	logic               lead_zero_d;
	logic               save_en;
	logic [SAVED_W-1:0] parts_seen_d;
	logic               stopped_d;
	logic               failed_d;
	logic [7:0]         saved_d [MAX_PARTS-1];

	logic        advance;
	logic [7:0]  c;
	logic        taken;
	logic [31:0] acc_cur;
	logic [31:0] acc_scaled;
	logic [3:0]  digit;
	logic [31:0] packed_addr;

	assign c = item_s1.text_byte;

	// handshake: a word leaves stage 1 unless it needs a busy result slot
	assign advance = valid_s1 && (!item_s1.final_byte || !valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result = result_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// character classification and one step of the part accumulator
	always_comb begin
		acc_d        = acc_q;
		base_d       = base_q;
		part_start_d = part_start_q;
		lead_zero_d  = lead_zero_q;
		parts_seen_d = parts_seen_q;
		stopped_d    = stopped_q;
		failed_d     = failed_q;
		save_en      = 1'b0;
		taken        = 1'b0;
		acc_cur      = part_start_q ? 32'd0 : acc_q;
		digit        = (c <= CHR_NINE) ? c[3:0] : 4'(c[2:0]) + 4'd9;

		if (!failed_q && !stopped_q) begin
			// start of a part, or the character after a leading zero
			if (part_start_q) begin
				part_start_d = 1'b0;
				lead_zero_d  = 1'b0;
				acc_d        = 32'd0;
				base_d       = BASE_DEC;
				if (c == CHR_ZERO) begin
					base_d      = BASE_OCT;
					lead_zero_d = 1'b1;
					taken       = 1'b1;
				end
			end else if (lead_zero_q) begin
				lead_zero_d = 1'b0;
				if (c == CHR_LX || c == CHR_UX) begin
					base_d = BASE_HEX;
					taken  = 1'b1;
				end
			end

			if (!taken) begin
				if (c inside {[CHR_ZERO:CHR_NINE]}) begin
					if (base_d == BASE_OCT && c[3:0] >= 4'd8) begin
						failed_d = 1'b1;
					end else begin
						acc_d = acc_scaled + 32'(digit);
					end
				end else if (base_d == BASE_HEX &&
						(c inside {[CHR_LA:CHR_LF]} || c inside {[CHR_UA:CHR_UF]})) begin
					acc_d = acc_scaled + 32'(digit);
				end else if (c == CHR_DOT) begin
					if (32'(parts_seen_q) >= MAX_PARTS - 1) begin
						failed_d = 1'b1;
					end else begin
						save_en      = 1'b1;
						parts_seen_d = parts_seen_q + 1'b1;
						acc_d        = 32'd0;
						base_d       = BASE_DEC;
						part_start_d = 1'b1;
						lead_zero_d  = 1'b0;
					end
				end else if (c == CHR_NUL || c == CHR_SPACE || c inside {[CHR_TAB:CHR_CR]}) begin
					stopped_d = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end
		end
	end

	// radix scaling by shifts
	always_comb begin
		case (base_d)
			BASE_HEX: acc_scaled = {acc_cur[27:0], 4'd0};
			BASE_OCT: acc_scaled = {acc_cur[28:0], 3'd0};
			BASE_DEC: acc_scaled = {acc_cur[28:0], 3'd0} + {acc_cur[30:0], 1'b0};
			default:  acc_scaled = 32'd0;
		endcase
	end

	// saved parts including one closed by this character
	always_comb begin
		for (int i = 0; i < MAX_PARTS - 1; i++) begin
			saved_d[i] = (save_en && parts_seen_q == SAVED_W'(i)) ? acc_cur[7:0] : saved_q[i];
		end
	end

	// pack the parts, last part fills the low bits
	always_comb begin
		case (parts_seen_d)
			2'd0:    packed_addr = acc_d;
			2'd1:    packed_addr = {saved_d[0], acc_d[23:0]};
			2'd2:    packed_addr = {saved_d[0], saved_d[1], acc_d[15:0]};
			default: packed_addr = {saved_d[0], saved_d[1], saved_d[2], acc_d[7:0]};
		endcase
	end

	// parse state, back to reset after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= 32'd0;
			base_q       <= BASE_DEC;
			part_start_q <= 1'b1;
			lead_zero_q  <= 1'b0;
			parts_seen_q <= '0;
			stopped_q    <= 1'b0;
			failed_q     <= 1'b0;
			for (int i = 0; i < MAX_PARTS - 1; i++) begin
				saved_q[i] <= 8'd0;
			end
		end else if (advance) begin
			if (item_s1.final_byte) begin
				acc_q        <= 32'd0;
				base_q       <= BASE_DEC;
				part_start_q <= 1'b1;
				lead_zero_q  <= 1'b0;
				parts_seen_q <= '0;
				stopped_q    <= 1'b0;
				failed_q     <= 1'b0;
				for (int i = 0; i < MAX_PARTS - 1; i++) begin
					saved_q[i] <= 8'd0;
				end
			end else begin
				acc_q        <= acc_d;
				base_q       <= base_d;
				part_start_q <= part_start_d;
				lead_zero_q  <= lead_zero_d;
				parts_seen_q <= parts_seen_d;
				stopped_q    <= stopped_d;
				failed_q     <= failed_d;
				if (save_en) begin
					saved_q[parts_seen_q] <= acc_cur[7:0];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && item_s1.final_byte) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.final_byte) begin
			result_s2.address <= failed_d ? 32'd0 : packed_addr;
			result_s2.ok      <= !failed_d;
		end
	end

`ifndef SYNTHESIS
	// a failed string always reports a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.ok || result.address == 32'd0))
		else $error("failed result carries a nonzero address");

	// a string cannot both end cleanly and fail
	assert property (@(posedge clk) disable iff (!arst_n)
		!(stopped_q && failed_q))
		else $error("parser both stopped and failed");

	// a final character leaves the parser in its start state
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.final_byte) |=>
		(part_start_q && parts_seen_q == '0 && !failed_q && !stopped_q && valid_s2))
		else $error("parse state not cleared after final character");
`endif

endmodule
